/* rtl/ikc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikc_pkg
// Shared types and fixed widths of the 5x5 image convolution engine.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
package ikc_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] REG_TAPS_0_7   = 3'd0;
    localparam logic [2:0] REG_TAPS_8_15  = 3'd1;
    localparam logic [2:0] REG_TAPS_16_23 = 3'd2;
    localparam logic [2:0] REG_TAP_24     = 3'd3;
    localparam logic [2:0] REG_DIVISOR    = 3'd4;
    localparam logic [2:0] REG_BIAS       = 3'd5;
    localparam logic [2:0] REG_WIDTH      = 3'd6;
    localparam logic [2:0] REG_HEIGHT     = 3'd7;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    localparam int SIZE_W  = 9;   // frame size registers
    localparam int POS_W   = 2 * SIZE_W;
    localparam int COORD_W = SIZE_W + 2;
    localparam int SUM_W   = 21;  // 25 taps of 8u x 8s
    localparam int DIV_N   = 21;  // dividend bits of the shared divider
    localparam int DEN_W   = 10;
    localparam int TAPS    = 25;
    localparam int PIX_MAX = 255;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_POSDIV = 5'b00010,
        ST_TAPS   = 5'b00100,
        ST_QDIV   = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

endpackage

/* rtl/image_kernel_convolution.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_kernel_convolution
// Frame store plus 5x5 convolution: load pixels, then emit filtered pixels.
// ----------------------------------------------------------------------------
//  channel | direction | ports                                  | handshake
//  s_      | in        | s_cmd, s_pixel_in                      | s_valid/s_ready
//  m_      | out       | m_pixel_out, m_end_of_frame, m_frame_ready | m_valid/m_ready
//  cfg_    | in        | cfg_addr, cfg_wdata                    | cfg_we
//
//  A load request writes the frame RAM as it is accepted.
//  An emit request on a complete frame runs through the row/column split
//  on the shared radix-2 divider, the 25 frame RAM reads (one read port,
//  then a drain of the multiply and accumulate registers), the divide by
//  the divisor and the result register; otherwise it goes straight to the result.
//  Requests are taken only in the idle state; the result register frees the
//  input side while a result waits for m_ready.
//  Reset (aresetn, synchronous) clears control state; the RAM is not cleared.
// ----------------------------------------------------------------------------
module image_kernel_convolution #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 256,
    parameter int KERNEL_SIZE = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_pixel_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_pixel_out,
    output logic        m_end_of_frame,
    output logic        m_frame_ready
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int RAD   = (KERNEL_SIZE - 1) / 2;
    localparam int SW    = ikc_pkg::SIZE_W;
    localparam int PW    = ikc_pkg::POS_W;
    localparam int CW    = ikc_pkg::COORD_W;
    localparam int DN    = ikc_pkg::DIV_N;
    localparam int DW    = ikc_pkg::DEN_W;

    // configuration registers
    logic [63:0]    taps0_reg, taps1_reg, taps2_reg;
    logic [7:0]     tap24_reg;
    logic [DW-1:0]  divisor_reg;
    logic [8:0]     bias_reg;
    logic [SW-1:0]  width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taps0_reg   <= '0;
            taps1_reg   <= '0;
            taps2_reg   <= '0;
            tap24_reg   <= '0;
            divisor_reg <= DW'(1);
            bias_reg    <= '0;
            width_reg   <= SW'(256);
            height_reg  <= SW'(256);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                ikc_pkg::REG_TAPS_0_7:   taps0_reg   <= cfg_wdata;
                ikc_pkg::REG_TAPS_8_15:  taps1_reg   <= cfg_wdata;
                ikc_pkg::REG_TAPS_16_23: taps2_reg   <= cfg_wdata;
                ikc_pkg::REG_TAP_24:     tap24_reg   <= cfg_wdata[7:0];
                ikc_pkg::REG_DIVISOR:    divisor_reg <= cfg_wdata[DW-1:0];
                ikc_pkg::REG_BIAS:       bias_reg    <= cfg_wdata[8:0];
                ikc_pkg::REG_WIDTH:      width_reg   <= cfg_wdata[SW-1:0];
                ikc_pkg::REG_HEIGHT:     height_reg  <= cfg_wdata[SW-1:0];
                default: ;
            endcase
        end
    end

    // clamped frame size and pixel count
    logic [SW-1:0] w_c, h_c;
    logic [PW-1:0] total;

    always_comb begin
        if (width_reg < SW'(3))                  w_c = SW'(3);
        else if (32'(width_reg) > MAX_WIDTH)     w_c = SW'(MAX_WIDTH);
        else                                     w_c = width_reg;
        if (height_reg < SW'(3))                 h_c = SW'(3);
        else if (32'(height_reg) > MAX_HEIGHT)   h_c = SW'(MAX_HEIGHT);
        else                                     h_c = height_reg;
        total = PW'(w_c) * PW'(h_c);
    end

    // control and datapath registers
    ikc_pkg::state_t state_reg, state_next;
    logic [PW-1:0]  load_pos_reg, emit_pos_reg;
    logic           complete_reg;
    logic           eof_reg;
    logic [SW-1:0]  y_reg, x_reg;
    logic [DW-1:0]  den_reg;
    logic [DW:0]    rem_reg;
    logic [DN-1:0]  quo_reg;
    logic [4:0]     div_cnt_reg;
    logic [4:0]     iss_cnt_reg;
    logic [2:0]     row_reg, col_reg;
    logic           v1_reg, v2_reg;
    logic signed [7:0]  coef1_reg;
    logic signed [16:0] prod_reg;
    logic signed [ikc_pkg::SUM_W-1:0] acc_reg;
    logic           neg_reg;
    logic           m_valid_reg;
    logic [7:0]     pix_reg;
    logic           res_eof_reg, res_rdy_reg, eof_out_reg, rdy_out_reg;

    logic s_fire, is_load, is_emit;
    assign s_ready = (state_reg == ikc_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign is_load = s_fire && (s_cmd == ikc_pkg::CMD_LOAD);
    assign is_emit = s_fire && (s_cmd == ikc_pkg::CMD_EMIT);

    // load path
    logic [PW-1:0] lp;
    assign lp = (load_pos_reg >= total) ? '0 : load_pos_reg;

    // emit position
    logic [PW-1:0] ep, ep_inc;
    assign ep     = (emit_pos_reg >= total) ? '0 : emit_pos_reg;
    assign ep_inc = ep + PW'(1);

    // shared radix-2 divider step
    logic [DW:0] rem_sh;
    logic        ge;
    assign rem_sh = {rem_reg[DW-1:0], quo_reg[DN-1]};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    // neighbour address for the tap being issued
    logic signed [CW-1:0] ny, nx;
    logic [SW-1:0] fy, fx;
    logic [PW-1:0] naddr;

    always_comb begin
        ny = $signed({2'b00, y_reg}) + $signed(CW'(row_reg)) - CW'(2);
        nx = $signed({2'b00, x_reg}) + $signed(CW'(col_reg)) - CW'(2);
        if (ny < 0)                           fy = SW'(-ny);
        else if (ny >= $signed({2'b00, h_c})) fy = SW'(ny - $signed({2'b00, h_c}));
        else                                  fy = SW'(ny);
        if (nx < 0)                           fx = SW'(-nx);
        else if (nx >= $signed({2'b00, w_c})) fx = SW'(nx - $signed({2'b00, w_c}));
        else                                  fx = SW'(nx);
        naddr = PW'(fy) * PW'(w_c) + PW'(fx);
    end

    // coefficient of the issued tap; outer ring forced to zero for small kernels
    logic [199:0] coef_all;
    logic [7:0]   coef_sel;
    logic         in_kernel;
    assign coef_all  = {tap24_reg, taps2_reg, taps1_reg, taps0_reg};
    assign in_kernel = (32'(row_reg) >= 2 - RAD) && (32'(row_reg) <= 2 + RAD) &&
                       (32'(col_reg) >= 2 - RAD) && (32'(col_reg) <= 2 + RAD);
    assign coef_sel  = in_kernel ? coef_all[iss_cnt_reg * 8 +: 8] : 8'd0;

    logic issuing;
    assign issuing = (state_reg == ikc_pkg::ST_TAPS) &&
                     (iss_cnt_reg < 5'(ikc_pkg::TAPS));

    ikc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (is_load),
        .wr_addr (AW'(lp)),
        .wr_data (s_pixel_in),
        .rd_en   (issuing),
        .rd_addr (AW'(naddr)),
        .rd_data (pix_reg)
    );

    // final scaling: sign, bias, clamp and magnitude
    logic signed [DN+2:0] qs, qb;
    logic [7:0] res_calc;

    always_comb begin
        qs = neg_reg ? -$signed({3'b000, quo_reg}) : $signed({3'b000, quo_reg});
        qb = qs + (DN+3)'($signed(bias_reg));
        if (qb > (DN+3)'(ikc_pkg::PIX_MAX))       res_calc = 8'(ikc_pkg::PIX_MAX);
        else if (qb >= 0)                          res_calc = qb[7:0];
        else if (-qb > (DN+3)'(ikc_pkg::PIX_MAX))  res_calc = 8'(ikc_pkg::PIX_MAX);
        else                                       res_calc = 8'(-qb);
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    // state sequencing
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ikc_pkg::ST_IDLE: begin
                if (is_emit) begin
                    state_next = complete_reg ? ikc_pkg::ST_POSDIV : ikc_pkg::ST_FINISH;
                end
            end
            ikc_pkg::ST_POSDIV: begin
                if (div_cnt_reg == 5'(DN - 1)) state_next = ikc_pkg::ST_TAPS;
            end
            ikc_pkg::ST_TAPS: begin
                if (!issuing && !v1_reg && !v2_reg) state_next = ikc_pkg::ST_QDIV;
            end
            ikc_pkg::ST_QDIV: begin
                if (div_cnt_reg == 5'(DN - 1)) state_next = ikc_pkg::ST_FINISH;
            end
            ikc_pkg::ST_FINISH: begin
                if (out_free) state_next = ikc_pkg::ST_IDLE;
            end
            default: state_next = ikc_pkg::ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ikc_pkg::ST_IDLE;
            load_pos_reg <= '0;
            emit_pos_reg <= '0;
            complete_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            div_cnt_reg  <= '0;
            iss_cnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (is_load) begin
                if (lp == '0) begin
                    complete_reg <= 1'b0;
                    emit_pos_reg <= '0;
                end
                if (lp + PW'(1) >= total) begin
                    complete_reg <= 1'b1;
                    load_pos_reg <= '0;
                end else begin
                    load_pos_reg <= lp + PW'(1);
                end
            end
            if (is_emit && complete_reg) begin
                emit_pos_reg <= (ep_inc == total) ? '0 : ep_inc;
            end
            if (state_reg == ikc_pkg::ST_POSDIV || state_reg == ikc_pkg::ST_QDIV) begin
                div_cnt_reg <= (div_cnt_reg == 5'(DN - 1)) ? '0 : div_cnt_reg + 5'd1;
            end
            if (state_reg == ikc_pkg::ST_POSDIV) begin
                iss_cnt_reg <= '0;
            end else if (issuing) begin
                iss_cnt_reg <= iss_cnt_reg + 5'd1;
            end
            v1_reg <= issuing;
            v2_reg <= v1_reg;
            if (state_reg == ikc_pkg::ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        // emit start: split position into row and column
        if (is_emit) begin
            eof_reg     <= (ep_inc == total);
            den_reg     <= DW'(w_c);
            rem_reg     <= '0;
            quo_reg     <= DN'(ep);
            res_eof_reg <= 1'b0;
            res_rdy_reg <= 1'b0;
        end
        if (state_reg == ikc_pkg::ST_POSDIV || state_reg == ikc_pkg::ST_QDIV) begin
            rem_reg <= ge ? rem_sh - {1'b0, den_reg} : rem_sh;
            quo_reg <= {quo_reg[DN-2:0], ge};
        end
        if (state_reg == ikc_pkg::ST_POSDIV && div_cnt_reg == 5'(DN - 1)) begin
            y_reg   <= SW'({quo_reg[DN-2:0], ge});
            x_reg   <= SW'(ge ? rem_sh - {1'b0, den_reg} : rem_sh);
            row_reg <= '0;
            col_reg <= '0;
            acc_reg <= '0;
        end
        // tap issue: walk rows and columns
        if (issuing) begin
            coef1_reg <= $signed(coef_sel);
            if (col_reg == 3'd4) begin
                col_reg <= '0;
                row_reg <= row_reg + 3'd1;
            end else begin
                col_reg <= col_reg + 3'd1;
            end
        end
        if (v1_reg) begin
            prod_reg <= $signed({1'b0, pix_reg}) * coef1_reg;
        end
        if (v2_reg) begin
            acc_reg <= acc_reg + ikc_pkg::SUM_W'(prod_reg);
        end
        // tap sum done: start magnitude divide
        if (state_reg == ikc_pkg::ST_TAPS && state_next == ikc_pkg::ST_QDIV) begin
            neg_reg <= acc_reg[ikc_pkg::SUM_W-1];
            quo_reg <= acc_reg[ikc_pkg::SUM_W-1] ? DN'(-acc_reg) : DN'(acc_reg);
            rem_reg <= '0;
            den_reg <= (divisor_reg == '0) ? DW'(1) : divisor_reg;
        end
        if (state_reg == ikc_pkg::ST_QDIV && div_cnt_reg == 5'(DN - 1)) begin
            res_rdy_reg <= 1'b1;
            res_eof_reg <= eof_reg;
        end
        // result register
        if (state_reg == ikc_pkg::ST_FINISH && out_free) begin
            rdy_out_reg <= res_rdy_reg;
            eof_out_reg <= res_eof_reg;
        end
    end

    // result pixel captured once the quotient is final
    logic [7:0] pix_out_reg;
    always_ff @(posedge aclk) begin
        if (state_reg == ikc_pkg::ST_FINISH && out_free) begin
            pix_out_reg <= res_rdy_reg ? res_calc : 8'd0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_out    = pix_out_reg;
    assign m_end_of_frame = eof_out_reg;
    assign m_frame_ready  = rdy_out_reg;

    // checks
    a_eof_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_frame |-> m_frame_ready)
        else $error("end of frame without a ready frame");

    a_not_ready_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_ready |-> m_pixel_out == 8'd0)
        else $error("pixel from an incomplete frame");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ikc_pkg::ST_TAPS) |-> x_reg < w_c && y_reg < h_c)
        else $error("row/column split out of range");

    a_pipe_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ikc_pkg::ST_QDIV |-> !v1_reg && !v2_reg &&
        iss_cnt_reg == 5'(ikc_pkg::TAPS))
        else $error("divide started before all taps were summed");

endmodule

/* rtl/ikc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
module ikc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* test/image_kernel_convolution_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_kernel_convolution_tb
// Loads frames and emits filtered pixels through the request channel while
// the coefficient, divisor, bias and frame size registers change between
// phases. Every emit result is checked against an in-bench 5x5 filter with
// its own frame store, under random idling on both channels.
// ----------------------------------------------------------------------------
module image_kernel_convolution_tb;

    typedef struct {
        logic       cmd;
        logic [7:0] pixel;
    } pix_req_t;

    typedef struct {
        logic [7:0] pixel;
        logic       eof;
        logic       ready;
    } filt_px_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = ikc_pkg::REG_TAPS_0_7;
    logic [63:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_cmd = ikc_pkg::CMD_LOAD;
    logic [7:0]  s_pixel_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_pixel_out;
    logic        m_end_of_frame;
    logic        m_frame_ready;

    // stimulus and expectations
    pix_req_t pending_reqs[$];
    filt_px_t expected_px[$];
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    logic     hold_req = 1'b0;
    int       hold_left = 0;
    logic     hold_off;
    int       err_count = 0;
    int       req_count = 0;
    int       written_hi = 0;

    // register mirror
    logic [63:0] taps_lo, taps_mid, taps_hi;
    logic [7:0]  tap_br;
    logic [9:0]  div_reg;
    logic [8:0]  bias_reg, w_reg, h_reg;

    // filter state mirror
    logic [7:0] frame_mem [0:65535];
    int         ld_pos, em_pos;
    logic       complete;

    image_kernel_convolution u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_pixel_in     (s_pixel_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_out    (m_pixel_out),
        .m_end_of_frame (m_end_of_frame),
        .m_frame_ready  (m_frame_ready)
    );

    always #5 aclk = ~aclk;

    // long receiver hold-off, counted in cycles
    always @(posedge aclk) begin
        if (hold_req) hold_left <= 400;
        else if (hold_left > 0) hold_left <= hold_left - 1;
    end
    assign hold_off = (hold_left > 0);

    function automatic int clamp_dim(logic [8:0] v);
        if (v < 3) return 3;
        if (v > 256) return 256;
        return int'(v);
    endfunction

    function automatic int tap_coef(int t);
        logic [7:0] b;
        if (t == 24) b = tap_br;
        else if (t < 8) b = taps_lo[8*t +: 8];
        else if (t < 16) b = taps_mid[8*(t-8) +: 8];
        else b = taps_hi[8*(t-16) +: 8];
        return int'($signed(b));
    endfunction

    // mirror below zero, wrap at or past the size
    function automatic int fold_coord(int c, int size);
        if (c < 0) return -c;
        if (c >= size) return c - size;
        return c;
    endfunction

    function automatic logic [7:0] filter_at(int y, int x, int w, int h);
        int sum, d, q, r, c;
        sum = 0;
        for (int dr = -2; dr <= 2; dr++) begin
            for (int dc = -2; dc <= 2; dc++) begin
                r = fold_coord(y + dr, h);
                c = fold_coord(x + dc, w);
                sum += int'(frame_mem[r*w + c]) * tap_coef((dr + 2) * 5 + dc + 2);
            end
        end
        d = (div_reg == 0) ? 1 : int'(div_reg);
        q = sum / d + int'($signed(bias_reg));
        if (q > ikc_pkg::PIX_MAX) q = ikc_pkg::PIX_MAX;
        if (q < 0) q = -q;
        if (q > ikc_pkg::PIX_MAX) q = ikc_pkg::PIX_MAX;
        return q[7:0];
    endfunction

    // advance the mirror on an accepted request
    task automatic apply_request(logic cmd, logic [7:0] pix);
        int w, h, total, pos;
        filt_px_t r;
        w = clamp_dim(w_reg);
        h = clamp_dim(h_reg);
        total = w * h;
        if (cmd == ikc_pkg::CMD_LOAD) begin
            if (ld_pos >= total) ld_pos = 0;
            if (ld_pos == 0) begin
                complete = 1'b0;
                em_pos = 0;
            end
            frame_mem[ld_pos] = pix;
            ld_pos++;
            if (ld_pos >= total) begin
                complete = 1'b1;
                ld_pos = 0;
            end
        end else begin
            r = '{8'd0, 1'b0, 1'b0};
            if (complete) begin
                pos = (em_pos >= total) ? 0 : em_pos;
                r.pixel = filter_at(pos / w, pos % w, w, h);
                r.eof = (pos + 1 == total);
                r.ready = 1'b1;
                em_pos = (pos + 1 == total) ? 0 : pos + 1;
            end
            expected_px.push_back(r);
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        pix_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) apply_request(s_cmd, s_pixel_in);
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_cmd <= nxt.cmd;
                    s_pixel_in <= nxt.pixel;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        filt_px_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_px.size() == 0) begin
                    $error("unexpected result: pixel_out %0d", m_pixel_out);
                    err_count++;
                end else begin
                    e = expected_px.pop_front();
                    if (m_pixel_out !== e.pixel) begin
                        $error("pixel_out expected %0d actual %0d", e.pixel, m_pixel_out);
                        err_count++;
                    end
                    if (m_end_of_frame !== e.eof) begin
                        $error("end_of_frame expected %0d actual %0d", e.eof,
                               m_end_of_frame);
                        err_count++;
                    end
                    if (m_frame_ready !== e.ready) begin
                        $error("frame_ready expected %0d actual %0d", e.ready,
                               m_frame_ready);
                        err_count++;
                    end
                end
            end
            m_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            ikc_pkg::REG_TAPS_0_7:   taps_lo = val;
            ikc_pkg::REG_TAPS_8_15:  taps_mid = val;
            ikc_pkg::REG_TAPS_16_23: taps_hi = val;
            ikc_pkg::REG_TAP_24:     tap_br = val[7:0];
            ikc_pkg::REG_DIVISOR:    div_reg = val[9:0];
            ikc_pkg::REG_BIAS:       bias_reg = val[8:0];
            ikc_pkg::REG_WIDTH:      w_reg = val[8:0];
            ikc_pkg::REG_HEIGHT:     h_reg = val[8:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_req(logic cmd, logic [7:0] pix);
        pending_reqs.push_back('{cmd, pix});
        req_count++;
    endtask

    // one full frame, with emits mixed in as noise (those after its first load return zeros);
    // no emit ahead of the first load when that could read unloaded pixels
    task automatic load_frame(int fixed_pix, int noise_pct);
        int total;
        total = clamp_dim(w_reg) * clamp_dim(h_reg);
        for (int i = 0; i < total; i++) begin
            if ((i > 0 || total <= written_hi) && $urandom_range(99) < noise_pct)
                push_req(ikc_pkg::CMD_EMIT, 8'($urandom));
            push_req(ikc_pkg::CMD_LOAD,
                     (fixed_pix < 0) ? 8'($urandom) : 8'(fixed_pix + 255 * (i % 2)));
        end
        if (total > written_hi) written_hi = total;
    endtask

    task automatic push_emits(int n);
        repeat (n) push_req(ikc_pkg::CMD_EMIT, 8'($urandom));
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_valid || expected_px.size() > 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // coefficient sets: random, all minimum, all maximum, 3x3 inner, identity
    task automatic write_taps(int mode);
        logic [7:0]   t [0:24];
        logic [199:0] packed_taps;
        for (int i = 0; i < 25; i++) begin
            case (mode)
                1: t[i] = 8'h80;
                2: t[i] = 8'h7f;
                3: t[i] = (i/5 >= 1 && i/5 <= 3 && i%5 >= 1 && i%5 <= 3) ? 8'($urandom) : 8'h00;
                4: t[i] = (i == 12) ? 8'h01 : 8'h00;
                default: t[i] = 8'($urandom);
            endcase
            packed_taps[8*i +: 8] = t[i];
        end
        write_reg(ikc_pkg::REG_TAPS_0_7, packed_taps[63:0]);
        write_reg(ikc_pkg::REG_TAPS_8_15, packed_taps[127:64]);
        write_reg(ikc_pkg::REG_TAPS_16_23, packed_taps[191:128]);
        write_reg(ikc_pkg::REG_TAP_24, {56'd0, packed_taps[199:192]});
    endtask

    initial begin
        int phase, total, sel;
        taps_lo = '0; taps_mid = '0; taps_hi = '0; tap_br = '0;
        div_reg = 10'd1; bias_reg = '0; w_reg = 9'd256; h_reg = 9'd256;
        ld_pos = 0; em_pos = 0; complete = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: emit before any frame, tiny frame with saturating kernel
        push_emits(1);
        drain();
        write_taps(2);
        write_reg(ikc_pkg::REG_DIVISOR, 64'd0);
        write_reg(ikc_pkg::REG_BIAS, 64'h101);
        write_reg(ikc_pkg::REG_WIDTH, 64'd3);
        write_reg(ikc_pkg::REG_HEIGHT, 64'd3);
        load_frame(0, 0);
        push_emits(10);
        drain();
        // sizes below range clamp; frame repeats from the previous load
        write_taps(1);
        write_reg(ikc_pkg::REG_DIVISOR, 64'd1023);
        write_reg(ikc_pkg::REG_BIAS, 64'd255);
        write_reg(ikc_pkg::REG_WIDTH, 64'd1);
        write_reg(ikc_pkg::REG_HEIGHT, 64'd0);
        push_emits(3);
        load_frame(-1, 0);
        push_emits(3);
        drain();

        // random phases
        phase = 0;
        while (req_count < 1950) begin
            case (phase % 4)
                0: begin send_idle_pct <= 0;  recv_idle_pct <= 0;  end
                1: begin send_idle_pct <= 81; recv_idle_pct <= 0;  end
                2: begin send_idle_pct <= 0;  recv_idle_pct <= 81; end
                default: begin send_idle_pct <= 28; recv_idle_pct <= 28; end
            endcase
            write_taps($urandom_range(4));
            sel = $urandom_range(9);
            write_reg(ikc_pkg::REG_DIVISOR, (sel == 0) ? 64'd0 : (sel == 1) ? 64'd1 :
                      (sel == 2) ? 64'd1023 : 64'($urandom_range(1023)));
            sel = $urandom_range(5);
            write_reg(ikc_pkg::REG_BIAS, (sel == 0) ? 64'h101 : (sel == 1) ? 64'd255 :
                      64'($urandom_range(511)));
            if (phase == 5) begin
                write_reg(ikc_pkg::REG_WIDTH, 64'd256);
                write_reg(ikc_pkg::REG_HEIGHT, 64'd3);
            end else if (phase == 11) begin
                write_reg(ikc_pkg::REG_WIDTH, 64'd3);
                write_reg(ikc_pkg::REG_HEIGHT, 64'd511);
            end else if (phase % 7 == 3) begin
                write_reg(ikc_pkg::REG_WIDTH, 64'($urandom_range(511)));
                write_reg(ikc_pkg::REG_HEIGHT, 64'($urandom_range(2)));
            end else begin
                write_reg(ikc_pkg::REG_WIDTH, 64'($urandom_range(3, 12)));
                write_reg(ikc_pkg::REG_HEIGHT, 64'($urandom_range(3, 10)));
            end
            total = clamp_dim(w_reg) * clamp_dim(h_reg);
            // a shrunken frame keeps emitting from what is already stored
            if (total <= written_hi && $urandom_range(2) == 0)
                push_emits($urandom_range(1, 12));
            repeat ((total > 300) ? 1 : $urandom_range(1, 2)) begin
                load_frame(-1, (total > 300) ? 1 : 10);
                push_emits((total > 300) ? 30 : $urandom_range(1, total + 3));
            end
            if (phase == 2) begin
                // long receiver hold-off while requests keep coming
                @(posedge aclk);
                hold_req <= 1'b1;
                @(posedge aclk);
                hold_req <= 1'b0;
            end
            drain();
            phase++;
        end

        if (err_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
